>>> rtl/mcfoc_pkg.sv
package mcfoc_pkg;

  // channel count and field widths
  localparam int PIN_CHANNELS_DEF = 16;
  localparam int CH_BITS          = 4;
  localparam int PIN_BITS         = 16;

  // request opcodes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_APPLY = 2'd2;

  // report kinds
  localparam logic [1:0] KIND_SNAP    = 2'd0;
  localparam logic [1:0] KIND_FLICKER = 2'd1;
  localparam logic [1:0] KIND_PLAIN   = 2'd2;
  localparam logic [1:0] KIND_SCOM    = 2'd3;

  // mode byte kind field
  localparam logic [1:0] MODE_FLICKER = 2'b01;

  typedef struct packed {
    logic [1:0] opcode;
    logic [3:0] channel;
    logic [7:0] mode_value;
  } req_t;

  typedef struct packed {
    logic [1:0]  report_kind;
    logic [3:0]  report_channel;
    logic [6:0]  scom_code;
    logic [15:0] pin_levels;
    logic        last;
  } rpt_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic write;
    logic tick_step;
    logic upd_step;
    logic set_pending;
    logic clr_pending;
    logic idx_clr;
    logic emit_rpt;
    logic emit_snap;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] opcode;
    logic       pending;
    logic       ch_ok;
    logic       idx_last;
  } sts_t;

  // flicker half period in ticks, unknown index falls back to entry 0
  function automatic logic [7:0] period_of(input logic [3:0] sel);
    logic [7:0] p;
    case (sel)
      4'd0:    p = 8'd10;
      4'd1:    p = 8'd50;
      4'd2:    p = 8'd25;
      4'd3:    p = 8'd16;
      4'd4:    p = 8'd12;
      4'd5:    p = 8'd10;
      4'd6:    p = 8'd5;
      4'd7:    p = 8'd100;
      4'd8:    p = 8'd50;
      default: p = 8'd10;
    endcase
    return p;
  endfunction

endpackage

>>> rtl/mcfoc_ctrl.sv
module mcfoc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  mcfoc_pkg::sts_t   sts,
  output mcfoc_pkg::cmd_t   cmd
);
  import mcfoc_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_DISPATCH = 6'b000010,
    ST_TICK     = 6'b000100,
    ST_UPD      = 6'b001000,
    ST_RPT      = 6'b010000,
    ST_SNAP     = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  assign busy = (state_r != ST_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        cmd.idx_clr = 1'b1;
        case (sts.opcode)
          OP_WRITE: begin
            cmd.write = sts.ch_ok;
            state_nxt = ST_SNAP;
          end
          OP_TICK: state_nxt = ST_TICK;
          OP_APPLY: state_nxt = sts.pending ? ST_UPD : ST_SNAP;
          default: state_nxt = ST_SNAP;
        endcase
      end
      ST_TICK: begin
        cmd.tick_step = 1'b1;
        if (sts.idx_last) begin
          cmd.set_pending = 1'b1;
          state_nxt       = ST_SNAP;
        end
      end
      ST_UPD: begin
        cmd.upd_step = 1'b1;
        if (sts.idx_last) begin
          cmd.clr_pending = 1'b1;
          cmd.idx_clr     = 1'b1;
          state_nxt       = ST_RPT;
        end
      end
      ST_RPT: begin
        cmd.emit_rpt = 1'b1;
        if (sts.idx_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SNAP: begin
        cmd.emit_snap = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // an accepted request always leaves idle for dispatch
  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == ST_DISPATCH))
    else $error("accepted request did not reach dispatch");

  // a report pass starts only from the update pass
  a_rpt_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RPT) |-> ($past(state_r) == ST_UPD || $past(state_r) == ST_RPT))
    else $error("report pass entered without update pass");

  // report pass ends exactly on the last channel
  a_rpt_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RPT && !sts.idx_last) |=> (state_r == ST_RPT))
    else $error("report pass left early");

endmodule

>>> rtl/mcfoc_dpath.sv
module mcfoc_dpath #(
  parameter int PIN_CHANNELS = mcfoc_pkg::PIN_CHANNELS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mcfoc_pkg::req_t   in_req,
  input  mcfoc_pkg::cmd_t   cmd,
  output mcfoc_pkg::sts_t   sts,
  output logic              out_valid,
  output mcfoc_pkg::rpt_t   out_rpt
);
  import mcfoc_pkg::*;

  localparam int CH_W = (PIN_CHANNELS > 1) ? $clog2(PIN_CHANNELS) : 1;
  localparam logic [CH_BITS-1:0] IDX_LAST = CH_BITS'(PIN_CHANNELS - 1);

  req_t                 req_r;
  logic [7:0]           mode_r [PIN_CHANNELS];
  logic [7:0]           cnt_r  [PIN_CHANNELS];
  logic [PIN_CHANNELS-1:0] on_r;
  logic [PIN_BITS-1:0]  pin_r;
  logic                 pending_r;
  logic [CH_BITS-1:0]   idx_r;
  logic                 out_valid_r;
  rpt_t                 out_rpt_r;

  logic [CH_W-1:0]      idx_sel;
  logic [CH_W-1:0]      wr_sel;
  logic [7:0]           cur_mode;
  logic [7:0]           cur_cnt;
  logic [7:0]           period;
  logic [7:0]           cnt_inc;
  logic                 hit_high;
  logic                 hit_low;
  logic                 cur_flicker;

  assign idx_sel  = idx_r[CH_W-1:0];
  assign wr_sel   = req_r.channel[CH_W-1:0];
  assign cur_mode = mode_r[idx_sel];
  assign cur_cnt  = cnt_r[idx_sel];

  // flicker step for the walked channel
  assign period      = period_of(cur_mode[3:0]);
  assign cnt_inc     = cur_cnt + 8'd1;
  assign hit_high    = (cnt_inc == period);
  assign hit_low     = ({1'b0, cnt_inc} >= {period, 1'b0});
  assign cur_flicker = (cur_mode[7:6] == MODE_FLICKER);

  // status toward the controller
  assign sts.opcode   = req_r.opcode;
  assign sts.pending  = pending_r;
  assign sts.ch_ok    = ({1'b0, req_r.channel} < (CH_BITS + 1)'(PIN_CHANNELS));
  assign sts.idx_last = (idx_r == IDX_LAST);

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req;
    end
  end

  // channel walk counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.tick_step || cmd.upd_step || cmd.emit_rpt) begin
      idx_r <= idx_r + CH_BITS'(1);
    end
  end

  // channel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PIN_CHANNELS; i++) begin
        mode_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
      on_r      <= '0;
      pin_r     <= '0;
      pending_r <= 1'b0;
    end else begin
      if (cmd.write) begin
        mode_r[wr_sel] <= req_r.mode_value;
        pending_r      <= 1'b1;
      end
      if (cmd.set_pending) begin
        pending_r <= 1'b1;
      end
      if (cmd.clr_pending) begin
        pending_r <= 1'b0;
      end
      if (cmd.tick_step && on_r[idx_sel]) begin
        if (hit_high) begin
          pin_r[idx_r] <= 1'b1;
          cnt_r[idx_sel] <= cnt_inc;
        end else if (hit_low) begin
          pin_r[idx_r] <= 1'b0;
          cnt_r[idx_sel] <= '0;
        end else begin
          cnt_r[idx_sel] <= cnt_inc;
        end
      end
      if (cmd.upd_step) begin
        on_r[idx_sel] <= cur_flicker;
        if (!cur_flicker) begin
          cnt_r[idx_sel] <= '0;
          if (!cur_mode[7]) begin
            pin_r[idx_r] <= cur_mode[0];
          end
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_rpt || cmd.emit_snap;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_rpt) begin
      out_rpt_r.report_channel <= idx_r;
      out_rpt_r.pin_levels     <= pin_r;
      out_rpt_r.last           <= sts.idx_last;
      if (on_r[idx_sel]) begin
        out_rpt_r.report_kind <= KIND_FLICKER;
        out_rpt_r.scom_code   <= '0;
      end else if (cur_mode[7]) begin
        out_rpt_r.report_kind <= KIND_SCOM;
        out_rpt_r.scom_code   <= cur_mode[6:0];
      end else begin
        out_rpt_r.report_kind <= KIND_PLAIN;
        out_rpt_r.scom_code   <= '0;
      end
    end else if (cmd.emit_snap) begin
      out_rpt_r.report_kind    <= KIND_SNAP;
      out_rpt_r.report_channel <= '0;
      out_rpt_r.scom_code      <= '0;
      out_rpt_r.pin_levels     <= pin_r;
      out_rpt_r.last           <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rpt   = out_rpt_r;

  // pins beyond the channel count stay low
  a_pin_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((pin_r >> PIN_CHANNELS) == '0))
    else $error("pin set beyond channel count");

  // reports of one apply follow back to back with the same pin snapshot
  a_rpt_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_rpt_r.last) |=>
      (out_valid_r && $stable(out_rpt_r.pin_levels)))
    else $error("apply reports broken up or pins moved");

  // nothing follows the final result of a request
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_rpt_r.last) |=> !out_valid_r)
    else $error("result after final result");

endmodule

>>> rtl/multi_channel_flicker_output_controller.sv
// a write, unused opcode or idle apply goes from dispatch straight to a single snapshot result;
// a tick walks the channels one per cycle, then gives its snapshot; an apply with changes pending
// walks an update pass, then a report pass that gives one report per channel
// busy stays high until the sequencer is back in idle, and no new request is taken while busy
// results come on a strobe and are never stalled; reports of one apply come back to back
// synchronous active-low reset clears all mode bytes, counters, enables, pins and pending mark
module multi_channel_flicker_output_controller #(
  parameter int PIN_CHANNELS = mcfoc_pkg::PIN_CHANNELS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  mcfoc_pkg::req_t   in_req,
  output logic              out_valid,
  output mcfoc_pkg::rpt_t   out_rpt
);
  import mcfoc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  mcfoc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // channel state and result register
  mcfoc_dpath #(
    .PIN_CHANNELS (PIN_CHANNELS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_rpt   (out_rpt)
  );

endmodule
